// File: hdl/tlj_pkg.sv
package tlj_pkg;

	localparam int MAX_WIDTH = 64;
	localparam int BUF_DEPTH = (MAX_WIDTH + 1) / 2;

	localparam int LEN_W  = 7;
	localparam int SP_W   = 6;
	localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
	localparam int ADDR_W = $clog2(BUF_DEPTH);
	localparam int SUM_W  = LEN_W + 2;

	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [SP_W-1:0]   sp_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [SUM_W-1:0]  sum_t;

	typedef struct packed {
		logic  start;
		sp_t   dividend;
		addr_t divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		sp_t   quot;
		addr_t rem;
	} div_rsp_t;

endpackage

// File: hdl/text_line_justifier.sv
// Greedy full justification of a stream of word lengths. Each accepted word is
// buffered (up to 32 words per line) and nothing is emitted until the line
// closes, either because the next word would not fit with single spaces, the
// buffer is full or the word is marked final; the line is then played out as
// one beat per word, carrying the spaces that follow it. A closing line takes
// a setup step, then the restoring divider when its slack has to be spread
// over the gaps, and then for each word it holds a buffer read, an output load
// and an output beat, stretched by any back-pressure on the output. Input is
// not taken while a line is being emitted. line_width may be changed only while
// the block is idle.
module text_line_justifier (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                line_width_we,
	input  logic [6:0]          line_width,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [6:0]          word_length,
	input  logic                final_word,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [6:0]          out_word_length,
	output logic [5:0]          spaces_after,
	output logic                line_done,
	output logic                text_done
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_APPEND = 3'd1;
	localparam logic [2:0] ST_CALC   = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_RD     = 3'd4;
	localparam logic [2:0] ST_LOAD   = 3'd5;
	localparam logic [2:0] ST_WAIT   = 3'd6;

	logic [2:0]             state_q;
	tlj_pkg::len_t          width_q;
	tlj_pkg::cnt_t          count_q;
	tlj_pkg::len_t          letters_q;
	tlj_pkg::len_t          word_q;
	logic                   fin_q;
	logic                   last_q;
	tlj_pkg::addr_t         idx_q;
	tlj_pkg::sp_t           each_q;
	tlj_pkg::addr_t         extra_q;
	tlj_pkg::sp_t           pad_q;
	logic                   out_valid_q;
	tlj_pkg::len_t          out_len_q;
	tlj_pkg::sp_t           out_sp_q;
	logic                   out_ld_q;
	logic                   out_td_q;

	tlj_pkg::len_t          eff_w;
	tlj_pkg::len_t          word_c;
	logic                   close_first;
	tlj_pkg::cnt_t          gaps;
	tlj_pkg::sum_t          used;
	logic                   stretched;
	tlj_pkg::sum_t          pad_full;
	tlj_pkg::len_t          slack;
	logic                   word_end;
	logic [tlj_pkg::SP_W:0] sp_mid;
	tlj_pkg::len_t          ram_rdata;
	logic                   ram_we;
	tlj_pkg::div_req_t      div_req;
	tlj_pkg::div_rsp_t      div_rsp;
	logic                   in_beat;
	logic                   out_beat;

	assign in_ready = (state_q == ST_IDLE);
	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid_q && out_ready;

	always_comb begin
		eff_w = width_q;
		if (width_q == '0) begin
			eff_w = tlj_pkg::LEN_W'(1);
		end else if (width_q > tlj_pkg::LEN_W'(tlj_pkg::MAX_WIDTH)) begin
			eff_w = tlj_pkg::LEN_W'(tlj_pkg::MAX_WIDTH);
		end

		word_c = word_length;
		if (word_length == '0) begin
			word_c = tlj_pkg::LEN_W'(1);
		end
		if (word_c > eff_w) begin
			word_c = eff_w;
		end

		close_first = (count_q != '0) &&
			((tlj_pkg::SUM_W'(letters_q) + tlj_pkg::SUM_W'(count_q) +
			  tlj_pkg::SUM_W'(word_c) > tlj_pkg::SUM_W'(eff_w)) ||
			 (count_q >= tlj_pkg::CNT_W'(tlj_pkg::BUF_DEPTH)));

		gaps      = count_q - 1'b1;
		used      = tlj_pkg::SUM_W'(letters_q) + tlj_pkg::SUM_W'(gaps);
		stretched = !last_q && (used <= tlj_pkg::SUM_W'(eff_w)) && (gaps != '0);
		pad_full  = (used < tlj_pkg::SUM_W'(eff_w)) ?
			(tlj_pkg::SUM_W'(eff_w) - used) : '0;
		slack     = eff_w - letters_q;

		word_end  = (tlj_pkg::CNT_W'(idx_q) + 1'b1) == count_q;
		sp_mid    = {1'b0, each_q} + ((idx_q < extra_q) ? 1'b1 : 1'b0);
	end

	assign div_req.start    = (state_q == ST_CALC) && stretched;
	assign div_req.dividend = slack[tlj_pkg::SP_W-1:0];
	assign div_req.divisor  = gaps[tlj_pkg::ADDR_W-1:0];

	assign ram_we = (state_q == ST_APPEND);

	tlj_ram #(
		.WIDTH (tlj_pkg::LEN_W),
		.DEPTH (tlj_pkg::BUF_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[tlj_pkg::ADDR_W-1:0]),
		.wdata (word_q),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	tlj_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= tlj_pkg::LEN_W'(tlj_pkg::MAX_WIDTH);
			count_q     <= '0;
			letters_q   <= '0;
			last_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (line_width_we) begin
				width_q <= line_width;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						last_q  <= 1'b0;
						state_q <= close_first ? ST_CALC : ST_APPEND;
					end
				end
				ST_APPEND: begin
					count_q   <= count_q + 1'b1;
					letters_q <= letters_q + word_q;
					if (fin_q) begin
						last_q  <= 1'b1;
						state_q <= ST_CALC;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_CALC: begin
					idx_q   <= '0;
					state_q <= stretched ? ST_DIV : ST_RD;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_beat) begin
						out_valid_q <= 1'b0;
						if (out_ld_q) begin
							// Line fully delivered; the pending word goes in next,
							// unless this was the final line of the text.
							count_q   <= '0;
							letters_q <= '0;
							state_q   <= last_q ? ST_IDLE : ST_APPEND;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			word_q <= word_c;
			fin_q  <= final_word;
		end
		if (state_q == ST_CALC && !stretched) begin
			each_q  <= tlj_pkg::SP_W'(1);
			extra_q <= '0;
			pad_q   <= pad_full[tlj_pkg::SP_W-1:0];
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			each_q  <= div_rsp.quot;
			extra_q <= div_rsp.rem;
			pad_q   <= '0;
		end
		if (state_q == ST_LOAD) begin
			out_len_q <= ram_rdata;
			out_sp_q  <= word_end ? pad_q : sp_mid[tlj_pkg::SP_W-1:0];
			out_ld_q  <= word_end;
			out_td_q  <= word_end && last_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_word_length = out_len_q;
	assign spaces_after    = out_sp_q;
	assign line_done       = out_ld_q;
	assign text_done       = out_td_q;

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result beat is pending");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tlj_pkg::CNT_W'(tlj_pkg::BUF_DEPTH))
		else $error("line buffer overfilled");

	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && line_done) |=> (count_q == '0 && letters_q == '0))
		else $error("line buffer not emptied after its last beat");

	a_text_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && text_done) |-> line_done)
		else $error("end of text flagged inside a line");
`endif

endmodule

// File: hdl/tlj_ram.sv
module tlj_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/tlj_div.sv
module tlj_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tlj_pkg::div_req_t  req,
	output tlj_pkg::div_rsp_t  rsp
);

	localparam int STEP_W = $clog2(tlj_pkg::SP_W + 1);

	logic [STEP_W-1:0]          step_q;
	logic                       busy_q;
	logic                       done_q;
	tlj_pkg::sp_t               quo_q;
	tlj_pkg::addr_t             rem_q;
	tlj_pkg::addr_t             dsr_q;
	logic [tlj_pkg::ADDR_W:0]   trial;
	logic [tlj_pkg::ADDR_W:0]   diff;
	logic                       fits;

	// One quotient bit per cycle, restoring form.
	always_comb begin
		trial = {rem_q, quo_q[tlj_pkg::SP_W-1]};
		fits  = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(tlj_pkg::SP_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[tlj_pkg::SP_W-2:0], fits};
			rem_q <= fits ? diff[tlj_pkg::ADDR_W-1:0] : trial[tlj_pkg::ADDR_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// File: bench/text_line_justifier_test.sv
module text_line_justifier_test;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int TAIL_CYCLES   = 50;

	typedef struct {
		tlj_pkg::len_t len;
		logic fin;
	} word_item_t;

	typedef struct {
		tlj_pkg::len_t len;
		tlj_pkg::sp_t  sp;
		logic ld;
		logic td;
	} placed_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       line_width_we = 1'b0;
	logic [6:0] line_width = 7'd64;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [6:0] word_length = 7'd1;
	logic       final_word = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [6:0] out_word_length;
	logic [5:0] spaces_after;
	logic       line_done;
	logic       text_done;

	text_line_justifier u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.line_width_we   (line_width_we),
		.line_width      (line_width),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.word_length     (word_length),
		.final_word      (final_word),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_word_length (out_word_length),
		.spaces_after    (spaces_after),
		.line_done       (line_done),
		.text_done       (text_done)
	);

	always #2 clk = ~clk;

	word_item_t   word_queue[$];
	placed_word_t due_words[$];

	// Shadow of the block's register and line buffer.
	logic [6:0] width_reg = 7'd64;
	int         held_len[tlj_pkg::BUF_DEPTH];
	int         held_count = 0;
	int         held_letters = 0;

	int  errors = 0;
	int  words_fed = 0;
	int  words_checked = 0;
	int  lines_checked = 0;
	int  texts_checked = 0;
	int  widths_used = 0;
	int  send_idle_pct = 31;
	int  take_idle_pct = 31;
	bit  hold_flip = 1'b0;
	bit  hold_seen = 1'b0;
	int  hold_left = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		$display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic int columns();
		int w;
		w = width_reg;
		if (w == 0) w = 1;
		if (w > tlj_pkg::MAX_WIDTH) w = tlj_pkg::MAX_WIDTH;
		return w;
	endfunction

	// Play out the held line: justified, or left-aligned when it is the text's last
	// line, holds one word or no longer fits a width that has since been narrowed.
	function automatic void justify_line(input int cols, input bit last);
		placed_word_t pw;
		int gaps, used, each, extra, pad, i;
		gaps = (held_count > 0) ? held_count - 1 : 0;
		used = held_letters + gaps;
		each = 1;
		extra = 0;
		pad = 0;
		if (last || used > cols) begin
			pad = (used < cols) ? cols - used : 0;
		end else if (gaps == 0) begin
			pad = (held_letters < cols) ? cols - held_letters : 0;
		end else begin
			each = (cols - held_letters) / gaps;
			extra = (cols - held_letters) % gaps;
		end
		for (i = 0; i < held_count; i++) begin
			pw.len = tlj_pkg::len_t'(held_len[i]);
			pw.ld = (i == held_count - 1);
			pw.td = pw.ld && last;
			pw.sp = tlj_pkg::sp_t'(pw.ld ? pad : each + ((i < extra) ? 1 : 0));
			due_words = {due_words, pw};
		end
		held_count = 0;
		held_letters = 0;
	endfunction

	function automatic void take_word(input tlj_pkg::len_t wl, input logic fin);
		int cols, w;
		cols = columns();
		w = wl;
		if (w == 0) w = 1;
		if (w > cols) w = cols;
		if (held_count > 0 &&
			(held_letters + held_count + w > cols || held_count >= tlj_pkg::BUF_DEPTH))
			justify_line(cols, 1'b0);
		held_len[held_count] = w;
		held_count++;
		held_letters += w;
		if (fin) justify_line(cols, 1'b1);
	endfunction

	always @(posedge clk or negedge arst_n) begin : feed_words
		word_item_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				take_word(word_length, final_word);
				words_fed++;
			end
			if (!in_valid || in_ready) begin
				if (word_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					item = word_queue.pop_front();
					in_valid <= 1'b1;
					word_length <= item.len;
					final_word <= item.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_words
		placed_word_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_words.size() == 0) begin
					report_mismatch("beat with nothing due, word length", out_word_length, 0);
				end else begin
					want = due_words.pop_front();
					if (out_word_length !== want.len)
						report_mismatch("out_word_length", out_word_length, want.len);
					if (spaces_after !== want.sp)
						report_mismatch("spaces_after", spaces_after, want.sp);
					if (line_done !== want.ld)
						report_mismatch("line_done", line_done, want.ld);
					if (text_done !== want.td)
						report_mismatch("text_done", text_done, want.td);
					words_checked++;
					if (want.ld) lines_checked++;
					if (want.td) texts_checked++;
				end
			end
			// A long hold-off stalls the input while a line is being emitted.
			if (hold_seen != hold_flip) begin
				hold_seen = hold_flip;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= take_idle_pct);
			end
		end
	end

	task automatic push_word(input int len, input bit fin);
		word_item_t item;
		item.len = tlj_pkg::len_t'(len);
		item.fin = fin;
		word_queue = {word_queue, item};
	endtask

	task automatic set_width(input int v);
		@(posedge clk);
		line_width_we <= 1'b1;
		line_width <= v[6:0];
		width_reg = v[6:0];
		widths_used++;
		@(posedge clk);
		line_width_we <= 1'b0;
	endtask

	// Wait until the block has drained, then give it time to finish buffering.
	task automatic settle();
		while (word_queue.size() != 0 || in_valid || due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_text(input int count);
		int n, r, run, k;
		n = 0;
		while (n < count) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				// A run of one-letter words can fill a line to the buffer depth.
				run = $urandom_range(20, 40);
				for (k = 0; k < run; k++) push_word(1, 1'b0);
				n += run;
			end else begin
				if (r < 14) push_word($urandom_range(0, 127), $urandom_range(0, 99) < 7);
				else if (r < 35) push_word(1, $urandom_range(0, 99) < 7);
				else if (r < 50) push_word($urandom_range(1, columns()), $urandom_range(0, 99) < 7);
				else push_word($urandom_range(1, 8), $urandom_range(0, 99) < 7);
				n++;
			end
		end
	endtask

	initial begin : run_text
		int phase_widths[8];
		int ph;
		phase_widths = '{64, 1, 127, 2, 0, 33, 65, 64};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset width: clamping, single-word lines, even and uneven gaps.
		push_word(127, 1'b1);
		push_word(0, 1'b0);
		push_word(1, 1'b0);
		push_word(64, 1'b0);
		push_word(5, 1'b0);
		push_word(7, 1'b0);
		push_word(9, 1'b1);
		push_word(10, 1'b0);
		push_word(11, 1'b0);
		push_word(10, 1'b0);
		push_word(40, 1'b1);
		// Leave a wide line held, then narrow the width under it.
		push_word(20, 1'b0);
		push_word(20, 1'b0);
		settle();
		set_width(10);
		push_word(3, 1'b1);
		settle();
		set_width(0);
		push_word(5, 1'b0);
		push_word(1, 1'b1);
		settle();
		set_width(127);
		push_word(100, 1'b1);
		push_word(64, 1'b1);
		settle();

		for (ph = 0; ph < 8; ph++) begin
			set_width((ph == 5) ? $urandom_range(3, 63) : phase_widths[ph]);
			send_idle_pct = (ph == 0) ? 0 : 31;
			take_idle_pct = (ph == 0) ? 0 : 31;
			if (ph == 2) hold_flip = ~hold_flip;
			random_text(50);
			settle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Fed %0d words under %0d width settings, including clamped and zero lengths.",
			words_fed, widths_used);
		$display("Checked %0d placed words in %0d lines across %0d complete texts.",
			words_checked, lines_checked, texts_checked);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("Timed out with %0d words still due.", due_words.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
